@@ src/planar_bitmap_fill_engine_top_assert.svh @@
// Assertion macros for the planar bitmap fill engine.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef PLANAR_BITMAP_FILL_ENGINE_TOP_ASSERT_SVH
`define PLANAR_BITMAP_FILL_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication.
`define PBF_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbf assertion failed");

// Next-cycle implication.
`define PBF_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbf assertion failed");

// Condition that must never hold.
`define PBF_ASSERT_NEVER(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("pbf assertion failed");

`endif

@@ src/pbf_pkg.sv @@
`timescale 1ns / 1ps
package pbf_pkg;

   localparam int MODE_W          = 2;
   localparam int COORD_W         = 10;
   localparam int COLOR_W         = 4;
   localparam int RPLANE_W        = 2;
   localparam int ROFF_W          = 16;
   localparam int DATA_W          = 8;

   localparam int SCREEN_WIDTH_W  = 10;
   localparam int SCREEN_HEIGHT_W = 9;
   localparam int PLANE_COUNT_W   = 3;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 10;

   localparam logic [SCREEN_WIDTH_W-1:0]  SCREEN_WIDTH_RESET  = 10'd640;
   localparam logic [SCREEN_HEIGHT_W-1:0] SCREEN_HEIGHT_RESET = 9'd480;
   localparam logic [PLANE_COUNT_W-1:0]   PLANE_COUNT_RESET   = 3'd4;

   localparam int SCREEN_WIDTH_MIN  = 8;
   localparam int SCREEN_HEIGHT_MIN = 1;
   localparam int PLANE_COUNT_MIN   = 1;
   localparam int PIXEL_SHIFT       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_COUNT   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FILL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   localparam logic [DATA_W-1:0] BYTE_ALL = 8'hff;
   localparam logic [2:0]        BIT_LAST = 3'd7;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_START,
      ST_READ,
      ST_RDATA,
      ST_WALK,
      ST_NEXT,
      ST_RESP
   } seq_state_type;

   typedef struct packed {
      logic              rd_en;
      logic              mod_en;
      logic              set;
      logic [DATA_W-1:0] mask;
      logic              clr_en;
   } store_cmd_type;

   typedef struct packed {
      logic clearing;
      logic walking;
   } seq_status_type;

endpackage

@@ src/pbf_store.sv @@
`timescale 1ns / 1ps
module pbf_store #(
   parameter int DEPTH  = 153600,
   parameter int ADDR_W = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ADDR_W-1:0]             addr,
   input  pbf_pkg::store_cmd_type        cmd,
   output logic [pbf_pkg::DATA_W-1:0]    rdata
);

   logic [pbf_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic [pbf_pkg::DATA_W-1:0] rdata_ff;

   logic                       pend_ff, pend_in;
   logic                       pend_set_ff, pend_set_in;
   logic [pbf_pkg::DATA_W-1:0] pend_mask_ff, pend_mask_in;
   logic [ADDR_W-1:0]          pend_addr_ff, pend_addr_in;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [pbf_pkg::DATA_W-1:0] wr_data;

   // Modify the byte read in the previous cycle and write it back.
   always_comb begin
      pend_in      = cmd.rd_en && cmd.mod_en;
      pend_set_in  = cmd.set;
      pend_mask_in = cmd.mask;
      pend_addr_in = addr;
      wr_en        = pend_ff || cmd.clr_en;
      if (pend_ff) begin
         wr_addr = pend_addr_ff;
         wr_data = pend_set_ff ? (rdata_ff | pend_mask_ff) : (rdata_ff & ~pend_mask_ff);
      end else begin
         wr_addr = addr;
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      pend_set_ff  <= pend_set_in;
      pend_mask_ff <= pend_mask_in;
      pend_addr_ff <= pend_addr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= store_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/pbf_seq.sv @@
`timescale 1ns / 1ps
module pbf_seq #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 480,
   parameter int MAX_PLANES = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [pbf_pkg::MODE_W-1:0]             req_mode,
   input  logic [pbf_pkg::COORD_W-1:0]            req_pos_x,
   input  logic [pbf_pkg::COORD_W-1:0]            req_pos_y,
   input  logic [pbf_pkg::COORD_W-1:0]            req_rect_width,
   input  logic [pbf_pkg::COORD_W-1:0]            req_rect_height,
   input  logic [pbf_pkg::COLOR_W-1:0]            req_color,
   input  logic [pbf_pkg::RPLANE_W-1:0]           req_read_plane,
   input  logic [pbf_pkg::ROFF_W-1:0]             req_read_offset,
   input  logic [$clog2(MAX_WIDTH/8+1)-1:0]       cfg_bpr,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]        cfg_rows,
   input  logic [$clog2(MAX_PLANES+1)-1:0]        cfg_planes,
   output logic                                   res_valid,
   input  logic                                   res_ready,
   output logic [pbf_pkg::DATA_W-1:0]             res_read_data,
   output logic                                   res_was_read,
   output logic [((MAX_WIDTH/8)*MAX_HEIGHT*MAX_PLANES > 1 ?
                  $clog2((MAX_WIDTH/8)*MAX_HEIGHT*MAX_PLANES) : 1)-1:0] mem_addr,
   output pbf_pkg::store_cmd_type                 mem_cmd,
   input  logic [pbf_pkg::DATA_W-1:0]             mem_rdata,
   output pbf_pkg::seq_status_type                status
);

   localparam int MAX_BPR = MAX_WIDTH / 8;
   localparam int BPR_W   = $clog2(MAX_BPR + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
   localparam int PCNT_W  = $clog2(MAX_PLANES + 1);
   localparam int PIDX_W  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
   localparam int CEXT_W  = 1 << PIDX_W;
   localparam int BPP_W   = $clog2(MAX_BPR * MAX_HEIGHT + 1);
   localparam int DEPTH   = MAX_BPR * MAX_HEIGHT * MAX_PLANES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW      = BPR_W + pbf_pkg::PIXEL_SHIFT;
   localparam int CW      = ((XW > pbf_pkg::COORD_W) ? XW : pbf_pkg::COORD_W) + 1;
   localparam int YW      = ((ROW_W > pbf_pkg::COORD_W) ? ROW_W : pbf_pkg::COORD_W) + 1;
   localparam int PC_W    = (PCNT_W > pbf_pkg::RPLANE_W) ? PCNT_W : pbf_pkg::RPLANE_W;
   localparam int RO_W    = (BPP_W > pbf_pkg::ROFF_W) ? BPP_W : pbf_pkg::ROFF_W;
   localparam int RP_W    = pbf_pkg::RPLANE_W + BPP_W;
   localparam int RA_W    = ((RP_W > pbf_pkg::ROFF_W) ? RP_W : pbf_pkg::ROFF_W) + 1;
   localparam int BP_W    = BPR_W + ROW_W;
   localparam int RS_W    = YW + BPR_W;
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

   pbf_pkg::seq_state_type state_ff, state_in;

   logic [ADDR_W-1:0]                clr_addr_ff, clr_addr_in;
   logic [pbf_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [pbf_pkg::COORD_W-1:0]      x_ff, x_in;
   logic [pbf_pkg::COORD_W-1:0]      y_ff, y_in;
   logic [pbf_pkg::COORD_W-1:0]      w_ff, w_in;
   logic [pbf_pkg::COORD_W-1:0]      h_ff, h_in;
   logic [pbf_pkg::COLOR_W-1:0]      color_ff, color_in;
   logic [pbf_pkg::RPLANE_W-1:0]     rplane_ff, rplane_in;
   logic [pbf_pkg::ROFF_W-1:0]       roff_ff, roff_in;
   logic [BPR_W-1:0]                 first_b_ff, first_b_in;
   logic [BPR_W-1:0]                 last_b_ff, last_b_in;
   logic [pbf_pkg::DATA_W-1:0]       fmask_ff, fmask_in;
   logic [pbf_pkg::DATA_W-1:0]       lmask_ff, lmask_in;
   logic [ROW_W-1:0]                 rows_left_ff, rows_left_in;
   logic [BPP_W-1:0]                 bpp_ff, bpp_in;
   logic [ADDR_W-1:0]                row_start_ff, row_start_in;
   logic [ADDR_W-1:0]                line_start_ff, line_start_in;
   logic [ADDR_W-1:0]                addr_ff, addr_in;
   logic [BPR_W-1:0]                 byte_ff, byte_in;
   logic [PIDX_W-1:0]                plane_ff, plane_in;
   logic                             walk_ff, walk_in;
   logic [pbf_pkg::DATA_W-1:0]       res_data_ff, res_data_in;
   logic                             res_read_ff, res_read_in;

   logic [CW-1:0]     scr_w, x_c, w_c, w_room, w_clip, last_x;
   logic [YW-1:0]     scr_h, y_c, h_c, h_room, h_clip;
   logic              on_screen;
   logic [BP_W-1:0]   bpp_prod;
   logic [RS_W-1:0]   rs_prod;
   logic [RP_W-1:0]   rp_prod;
   logic [RA_W-1:0]   rd_sum;
   logic              rd_ok;
   logic              last_byte, last_plane, last_row;
   logic [CEXT_W-1:0] color_ext;
   logic [pbf_pkg::DATA_W-1:0] walk_mask;

   // Clip the span and lay out the walk.
   always_comb begin
      scr_w     = CW'({cfg_bpr, 3'b000});
      x_c       = CW'(x_ff);
      w_c       = CW'(w_ff);
      w_room    = scr_w - x_c;
      scr_h     = YW'(cfg_rows);
      y_c       = YW'(y_ff);
      h_c       = YW'(h_ff);
      h_room    = scr_h - y_c;
      on_screen = (x_c < scr_w) && (y_c < scr_h);
      if (mode_ff == pbf_pkg::MODE_PIXEL) begin
         w_clip = CW'(1);
         h_clip = YW'(1);
      end else begin
         w_clip = (w_c > w_room) ? w_room : w_c;
         h_clip = (h_c > h_room) ? h_room : h_c;
      end
      last_x   = x_c + w_clip - CW'(1);
      bpp_prod = BP_W'(cfg_bpr) * BP_W'(cfg_rows);
      rs_prod  = RS_W'(y_c) * RS_W'(cfg_bpr);
   end

   // Resolve the read address.
   always_comb begin
      rp_prod = RP_W'(rplane_ff) * RP_W'(bpp_ff);
      rd_sum  = RA_W'(rp_prod) + RA_W'(roff_ff);
      rd_ok   = (PC_W'(rplane_ff) < PC_W'(cfg_planes)) && (RO_W'(roff_ff) < RO_W'(bpp_ff));
   end

   always_comb begin
      last_byte  = (byte_ff == last_b_ff);
      last_plane = (PCNT_W'(plane_ff) == (cfg_planes - PCNT_W'(1)));
      last_row   = (rows_left_ff == ROW_W'(1));
      color_ext  = CEXT_W'(color_ff);
      walk_mask  = pbf_pkg::BYTE_ALL;
      if (byte_ff == first_b_ff) begin
         walk_mask = walk_mask & fmask_ff;
      end
      if (last_byte) begin
         walk_mask = walk_mask & lmask_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbf_pkg::ST_CLEAR: begin
            if (clr_addr_ff == CLR_LAST) begin
               state_in = pbf_pkg::ST_IDLE;
            end
         end
         pbf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pbf_pkg::ST_SETUP;
            end
         end
         pbf_pkg::ST_SETUP: begin
            state_in = pbf_pkg::ST_START;
         end
         pbf_pkg::ST_START: begin
            if (mode_ff == pbf_pkg::MODE_READ) begin
               state_in = rd_ok ? pbf_pkg::ST_READ : pbf_pkg::ST_RESP;
            end else if (walk_ff) begin
               state_in = pbf_pkg::ST_WALK;
            end else begin
               state_in = pbf_pkg::ST_RESP;
            end
         end
         pbf_pkg::ST_READ: begin
            state_in = pbf_pkg::ST_RDATA;
         end
         pbf_pkg::ST_RDATA: begin
            state_in = pbf_pkg::ST_RESP;
         end
         pbf_pkg::ST_WALK: begin
            if (last_byte) begin
               state_in = (last_plane && last_row) ? pbf_pkg::ST_RESP : pbf_pkg::ST_NEXT;
            end
         end
         pbf_pkg::ST_NEXT: begin
            state_in = pbf_pkg::ST_WALK;
         end
         pbf_pkg::ST_RESP: begin
            if (res_ready) begin
               state_in = pbf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      res_valid      = 1'b0;
      mem_addr       = addr_ff;
      mem_cmd.rd_en  = 1'b0;
      mem_cmd.mod_en = 1'b0;
      mem_cmd.set    = color_ext[plane_ff];
      mem_cmd.mask   = walk_mask;
      mem_cmd.clr_en = 1'b0;
      status.clearing = 1'b0;
      status.walking  = 1'b0;
      case (state_ff)
         pbf_pkg::ST_CLEAR: begin
            mem_addr        = clr_addr_ff;
            mem_cmd.clr_en  = 1'b1;
            status.clearing = 1'b1;
         end
         pbf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         pbf_pkg::ST_READ: begin
            mem_cmd.rd_en = 1'b1;
         end
         pbf_pkg::ST_WALK: begin
            mem_cmd.rd_en  = 1'b1;
            mem_cmd.mod_en = 1'b1;
            status.walking = 1'b1;
         end
         pbf_pkg::ST_NEXT: begin
            status.walking = 1'b1;
         end
         pbf_pkg::ST_RESP: begin
            res_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      clr_addr_in   = clr_addr_ff;
      mode_in       = mode_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      color_in      = color_ff;
      rplane_in     = rplane_ff;
      roff_in       = roff_ff;
      first_b_in    = first_b_ff;
      last_b_in     = last_b_ff;
      fmask_in      = fmask_ff;
      lmask_in      = lmask_ff;
      rows_left_in  = rows_left_ff;
      bpp_in        = bpp_ff;
      row_start_in  = row_start_ff;
      line_start_in = line_start_ff;
      addr_in       = addr_ff;
      byte_in       = byte_ff;
      plane_in      = plane_ff;
      walk_in       = walk_ff;
      res_data_in   = res_data_ff;
      res_read_in   = res_read_ff;
      case (state_ff)
         pbf_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         pbf_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               x_in      = req_pos_x;
               y_in      = req_pos_y;
               w_in      = req_rect_width;
               h_in      = req_rect_height;
               color_in  = req_color;
               rplane_in = req_read_plane;
               roff_in   = req_read_offset;
            end
         end
         pbf_pkg::ST_SETUP: begin
            first_b_in   = BPR_W'(x_c >> pbf_pkg::PIXEL_SHIFT);
            last_b_in    = BPR_W'(last_x >> pbf_pkg::PIXEL_SHIFT);
            fmask_in     = pbf_pkg::BYTE_ALL >> x_c[2:0];
            lmask_in     = pbf_pkg::BYTE_ALL << (pbf_pkg::BIT_LAST - last_x[2:0]);
            rows_left_in = ROW_W'(h_clip);
            bpp_in       = BPP_W'(bpp_prod);
            row_start_in = ADDR_W'(rs_prod);
            walk_in      = ((mode_ff == pbf_pkg::MODE_PIXEL) || (mode_ff == pbf_pkg::MODE_FILL))
                           && on_screen && (w_clip != '0) && (h_clip != '0);
         end
         pbf_pkg::ST_START: begin
            res_data_in = '0;
            res_read_in = (mode_ff == pbf_pkg::MODE_READ);
            if (mode_ff == pbf_pkg::MODE_READ) begin
               addr_in = ADDR_W'(rd_sum);
            end else begin
               addr_in = row_start_ff + ADDR_W'(first_b_ff);
            end
            line_start_in = row_start_ff;
            byte_in       = first_b_ff;
            plane_in      = '0;
         end
         pbf_pkg::ST_RDATA: begin
            res_data_in = mem_rdata;
         end
         pbf_pkg::ST_WALK: begin
            if (!last_byte) begin
               byte_in = byte_ff + BPR_W'(1);
               addr_in = addr_ff + ADDR_W'(1);
            end else if (!last_plane) begin
               plane_in      = plane_ff + PIDX_W'(1);
               line_start_in = line_start_ff + ADDR_W'(bpp_ff);
            end else begin
               rows_left_in  = rows_left_ff - ROW_W'(1);
               plane_in      = '0;
               row_start_in  = row_start_ff + ADDR_W'(cfg_bpr);
               line_start_in = row_start_ff + ADDR_W'(cfg_bpr);
            end
         end
         pbf_pkg::ST_NEXT: begin
            addr_in = line_start_ff + ADDR_W'(first_b_ff);
            byte_in = first_b_ff;
         end
         default: begin
            walk_in = walk_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pbf_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
      mode_ff       <= mode_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      color_ff      <= color_in;
      rplane_ff     <= rplane_in;
      roff_ff       <= roff_in;
      first_b_ff    <= first_b_in;
      last_b_ff     <= last_b_in;
      fmask_ff      <= fmask_in;
      lmask_ff      <= lmask_in;
      rows_left_ff  <= rows_left_in;
      bpp_ff        <= bpp_in;
      row_start_ff  <= row_start_in;
      line_start_ff <= line_start_in;
      addr_ff       <= addr_in;
      byte_ff       <= byte_in;
      plane_ff      <= plane_in;
      walk_ff       <= walk_in;
      res_data_ff   <= res_data_in;
      res_read_ff   <= res_read_in;
   end

   assign res_read_data = res_data_ff;
   assign res_was_read  = res_read_ff;

endmodule

@@ src/planar_bitmap_fill_engine_top.sv @@
// Channel   Direction  Handshake                   Payload
// req_      in         req_valid / req_ready       mode, position, size, color, read address
// rsp_      out        rsp_valid / rsp_ready       read_data, was_read
// csr_      in         csr_wr_en (no wait)         csr_index, csr_wdata
//
// After reset the frame store is cleared one byte per cycle: (MAX_WIDTH/8) * MAX_HEIGHT *
// MAX_PLANES bytes (153600 at the defaults); req_ready stays low until the sweep ends.
// One transaction is worked at a time on the single read-modify-write port of the store.
// A pixel or fill walks each clipped row byte by byte in every plane; an off-screen or
// empty draw, a bad read or mode 3 goes straight to the result without touching the store.
// A result waiting in the output register does not block the next transaction.
`timescale 1ns / 1ps
`include "planar_bitmap_fill_engine_top_assert.svh"
module planar_bitmap_fill_engine_top #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 480,
   parameter int MAX_PLANES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pbf_pkg::MODE_W-1:0]          req_mode,
   input  logic [pbf_pkg::COORD_W-1:0]         req_pos_x,
   input  logic [pbf_pkg::COORD_W-1:0]         req_pos_y,
   input  logic [pbf_pkg::COORD_W-1:0]         req_rect_width,
   input  logic [pbf_pkg::COORD_W-1:0]         req_rect_height,
   input  logic [pbf_pkg::COLOR_W-1:0]         req_color,
   input  logic [pbf_pkg::RPLANE_W-1:0]        req_read_plane,
   input  logic [pbf_pkg::ROFF_W-1:0]          req_read_offset,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pbf_pkg::DATA_W-1:0]          rsp_read_data,
   output logic                                rsp_was_read,
   input  logic                                csr_wr_en,
   input  logic [pbf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pbf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int MAX_BPR = MAX_WIDTH / 8;
   localparam int BPR_W   = $clog2(MAX_BPR + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
   localparam int PCNT_W  = $clog2(MAX_PLANES + 1);
   localparam int DEPTH   = MAX_BPR * MAX_HEIGHT * MAX_PLANES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW_W    = ($clog2(MAX_WIDTH + 1) > pbf_pkg::SCREEN_WIDTH_W) ?
                            $clog2(MAX_WIDTH + 1) : pbf_pkg::SCREEN_WIDTH_W;
   localparam int SH_W    = ($clog2(MAX_HEIGHT + 1) > pbf_pkg::SCREEN_HEIGHT_W) ?
                            $clog2(MAX_HEIGHT + 1) : pbf_pkg::SCREEN_HEIGHT_W;
   localparam int SP_W    = (PCNT_W > pbf_pkg::PLANE_COUNT_W) ? PCNT_W : pbf_pkg::PLANE_COUNT_W;
   localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(DEPTH);

   logic [pbf_pkg::SCREEN_WIDTH_W-1:0]  width_ff, width_in;
   logic [pbf_pkg::SCREEN_HEIGHT_W-1:0] height_ff, height_in;
   logic [pbf_pkg::PLANE_COUNT_W-1:0]   planes_ff, planes_in;

   logic [SW_W-1:0]   width_c, eff_width;
   logic [SH_W-1:0]   height_c, eff_height;
   logic [SP_W-1:0]   planes_c, eff_planes;
   logic [BPR_W-1:0]  cfg_bpr;
   logic [ROW_W-1:0]  cfg_rows;
   logic [PCNT_W-1:0] cfg_planes;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pbf_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                        rsp_read_ff, rsp_read_in;

   logic                        res_valid, res_ready;
   logic [pbf_pkg::DATA_W-1:0]  res_read_data;
   logic                        res_was_read;

   logic [ADDR_W-1:0]           mem_addr;
   logic [ADDR_W:0]             mem_addr_x;
   pbf_pkg::store_cmd_type      mem_cmd;
   logic [pbf_pkg::DATA_W-1:0]  mem_rdata;
   pbf_pkg::seq_status_type     status;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      planes_in = planes_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pbf_pkg::CSR_SCREEN_WIDTH: begin
               width_in = csr_wdata[pbf_pkg::SCREEN_WIDTH_W-1:0];
            end
            pbf_pkg::CSR_SCREEN_HEIGHT: begin
               height_in = csr_wdata[pbf_pkg::SCREEN_HEIGHT_W-1:0];
            end
            pbf_pkg::CSR_PLANE_COUNT: begin
               planes_in = csr_wdata[pbf_pkg::PLANE_COUNT_W-1:0];
            end
            default: begin
               planes_in = planes_ff;
            end
         endcase
      end
   end

   // Saturate the layout registers to the supported range.
   always_comb begin
      width_c  = SW_W'(width_ff);
      height_c = SH_W'(height_ff);
      planes_c = SP_W'(planes_ff);
      if (width_c < SW_W'(pbf_pkg::SCREEN_WIDTH_MIN)) begin
         eff_width = SW_W'(pbf_pkg::SCREEN_WIDTH_MIN);
      end else if (width_c > SW_W'(MAX_WIDTH)) begin
         eff_width = SW_W'(MAX_WIDTH);
      end else begin
         eff_width = width_c;
      end
      if (height_c < SH_W'(pbf_pkg::SCREEN_HEIGHT_MIN)) begin
         eff_height = SH_W'(pbf_pkg::SCREEN_HEIGHT_MIN);
      end else if (height_c > SH_W'(MAX_HEIGHT)) begin
         eff_height = SH_W'(MAX_HEIGHT);
      end else begin
         eff_height = height_c;
      end
      if (planes_c < SP_W'(pbf_pkg::PLANE_COUNT_MIN)) begin
         eff_planes = SP_W'(pbf_pkg::PLANE_COUNT_MIN);
      end else if (planes_c > SP_W'(MAX_PLANES)) begin
         eff_planes = SP_W'(MAX_PLANES);
      end else begin
         eff_planes = planes_c;
      end
      cfg_bpr    = BPR_W'(eff_width >> pbf_pkg::PIXEL_SHIFT);
      cfg_rows   = ROW_W'(eff_height);
      cfg_planes = PCNT_W'(eff_planes);
   end

   // Hold the result until the consumer takes it.
   always_comb begin
      res_ready    = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_read_in  = rsp_read_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_read_data;
         rsp_read_in  = res_was_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= pbf_pkg::SCREEN_WIDTH_RESET;
         height_ff    <= pbf_pkg::SCREEN_HEIGHT_RESET;
         planes_ff    <= pbf_pkg::PLANE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         planes_ff    <= planes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_read_ff <= rsp_read_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_was_read  = rsp_read_ff;

   pbf_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_PLANES (MAX_PLANES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_color       (req_color),
      .req_read_plane  (req_read_plane),
      .req_read_offset (req_read_offset),
      .cfg_bpr         (cfg_bpr),
      .cfg_rows        (cfg_rows),
      .cfg_planes      (cfg_planes),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res_read_data   (res_read_data),
      .res_was_read    (res_was_read),
      .mem_addr        (mem_addr),
      .mem_cmd         (mem_cmd),
      .mem_rdata       (mem_rdata),
      .status          (status)
   );

   pbf_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .addr  (mem_addr),
      .cmd   (mem_cmd),
      .rdata (mem_rdata)
   );

   assign mem_addr_x = (ADDR_W + 1)'(mem_addr);

   `PBF_ASSERT_IMP(a_busy_blocks_req, status.clearing || status.walking, !req_ready)
   `PBF_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
   `PBF_ASSERT_NEVER(a_clear_exclusive, mem_cmd.clr_en && (mem_cmd.rd_en || mem_cmd.mod_en))
   `PBF_ASSERT_IMP(a_addr_in_range, mem_cmd.rd_en || mem_cmd.clr_en, mem_addr_x < DEPTH_X)

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

   localparam int MAX_WIDTH   = 640;
   localparam int MAX_HEIGHT  = 480;
   localparam int MAX_PLANES  = 4;
   localparam int STORE_DEPTH = (MAX_WIDTH / 8) * MAX_HEIGHT * MAX_PLANES;
   localparam int MODE_W      = pbf_pkg::MODE_W;
   localparam int COORD_W     = pbf_pkg::COORD_W;
   localparam int COLOR_W     = pbf_pkg::COLOR_W;
   localparam int RPLANE_W    = pbf_pkg::RPLANE_W;
   localparam int ROFF_W      = pbf_pkg::ROFF_W;
   localparam int DATA_W      = pbf_pkg::DATA_W;
   localparam int CSR_INDEX_W = pbf_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = pbf_pkg::CSR_DATA_W;
   localparam int PIXEL_SHIFT = pbf_pkg::PIXEL_SHIFT;
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
      logic [COORD_W-1:0]  rect_width;
      logic [COORD_W-1:0]  rect_height;
      logic [COLOR_W-1:0]  color;
      logic [RPLANE_W-1:0] read_plane;
      logic [ROFF_W-1:0]   read_offset;
   } draw_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              was_read;
   } read_rsp_type;

   class bitmap_scoreboard;
      logic [DATA_W-1:0]                   frame_bytes [STORE_DEPTH];
      logic [pbf_pkg::SCREEN_WIDTH_W-1:0]  screen_width;
      logic [pbf_pkg::SCREEN_HEIGHT_W-1:0] screen_height;
      logic [pbf_pkg::PLANE_COUNT_W-1:0]   plane_count;
      read_rsp_type                        due_responses [$];
      int unsigned                         failures;

      function new();
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         screen_width  = pbf_pkg::SCREEN_WIDTH_RESET;
         screen_height = pbf_pkg::SCREEN_HEIGHT_RESET;
         plane_count   = pbf_pkg::PLANE_COUNT_RESET;
         failures      = 0;
      endfunction

      function int unsigned row_bytes();
         int unsigned w;
         w = screen_width;
         if (w < pbf_pkg::SCREEN_WIDTH_MIN) w = pbf_pkg::SCREEN_WIDTH_MIN;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w >> PIXEL_SHIFT;
      endfunction

      function int unsigned screen_cols();
         return row_bytes() << PIXEL_SHIFT;
      endfunction

      function int unsigned screen_rows();
         int unsigned h;
         h = screen_height;
         if (h < pbf_pkg::SCREEN_HEIGHT_MIN) h = pbf_pkg::SCREEN_HEIGHT_MIN;
         if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         return h;
      endfunction

      function int unsigned planes_used();
         int unsigned n;
         n = plane_count;
         if (n < pbf_pkg::PLANE_COUNT_MIN) n = pbf_pkg::PLANE_COUNT_MIN;
         if (n > MAX_PLANES) n = MAX_PLANES;
         return n;
      endfunction

      function int unsigned outstanding();
         return due_responses.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            pbf_pkg::CSR_SCREEN_WIDTH: begin
               screen_width = value[pbf_pkg::SCREEN_WIDTH_W-1:0];
            end
            pbf_pkg::CSR_SCREEN_HEIGHT: begin
               screen_height = value[pbf_pkg::SCREEN_HEIGHT_W-1:0];
            end
            pbf_pkg::CSR_PLANE_COUNT: begin
               plane_count = value[pbf_pkg::PLANE_COUNT_W-1:0];
            end
            default: ;
         endcase
      endfunction

      function void paint_span(int unsigned x, int unsigned y, int unsigned w,
                               logic [COLOR_W-1:0] color);
         int unsigned bpp, last_x, first_b, last_b, addr, p, b;
         logic [DATA_W-1:0] mask;
         bpp     = row_bytes() * screen_rows();
         last_x  = x + w - 1;
         first_b = x >> PIXEL_SHIFT;
         last_b  = last_x >> PIXEL_SHIFT;
         for (p = 0; p < planes_used(); p++) begin
            for (b = first_b; b <= last_b; b++) begin
               mask = pbf_pkg::BYTE_ALL;
               if (b == first_b) mask &= pbf_pkg::BYTE_ALL >> x[2:0];
               if (b == last_b) mask &= pbf_pkg::BYTE_ALL << (pbf_pkg::BIT_LAST - last_x[2:0]);
               addr = p * bpp + y * row_bytes() + b;
               if (addr < STORE_DEPTH) begin
                  if (color[p]) frame_bytes[addr] |= mask;
                  else frame_bytes[addr] &= ~mask;
               end
            end
         end
      endfunction

      function void note_request(draw_req_type r);
         int unsigned cols, rows, w, h, bpp, addr, row;
         read_rsp_type rsp;
         cols = screen_cols();
         rows = screen_rows();
         rsp  = '0;
         w    = r.rect_width;
         h    = r.rect_height;
         case (r.mode)
            pbf_pkg::MODE_PIXEL: begin
               if (r.pos_x < cols && r.pos_y < rows) paint_span(r.pos_x, r.pos_y, 1, r.color);
            end
            pbf_pkg::MODE_FILL: begin
               if (r.pos_x < cols && r.pos_y < rows) begin
                  if (w > cols - r.pos_x) w = cols - r.pos_x;
                  if (h > rows - r.pos_y) h = rows - r.pos_y;
                  if (w != 0) begin
                     for (row = 0; row < h; row++) paint_span(r.pos_x, r.pos_y + row, w, r.color);
                  end
               end
            end
            pbf_pkg::MODE_READ: begin
               rsp.was_read = 1'b1;
               bpp = row_bytes() * rows;
               if (r.read_plane < planes_used() && r.read_offset < bpp) begin
                  addr = r.read_plane * bpp + r.read_offset;
                  if (addr < STORE_DEPTH) rsp.read_data = frame_bytes[addr];
               end
            end
            default: ;
         endcase
         due_responses.push_back(rsp);
      endfunction

      function void check_result(logic [DATA_W-1:0] read_data, logic was_read);
         read_rsp_type want;
         if (due_responses.size() == 0) begin
            $display("%0t: response with none expected: read_data %02h was_read %0b",
                     $time, read_data, was_read);
            failures++;
            return;
         end
         want = due_responses.pop_front();
         if (read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %02h actual %02h",
                     $time, want.read_data, read_data);
            failures++;
         end
         if (was_read !== want.was_read) begin
            $display("%0t: was_read mismatch: expected %0b actual %0b",
                     $time, want.was_read, was_read);
            failures++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [MODE_W-1:0]      req_mode;
   logic [COORD_W-1:0]     req_pos_x;
   logic [COORD_W-1:0]     req_pos_y;
   logic [COORD_W-1:0]     req_rect_width;
   logic [COORD_W-1:0]     req_rect_height;
   logic [COLOR_W-1:0]     req_color;
   logic [RPLANE_W-1:0]    req_read_plane;
   logic [ROFF_W-1:0]      req_read_offset;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [DATA_W-1:0]      rsp_read_data;
   logic                   rsp_was_read;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bitmap_scoreboard screen_sb;
   int               req_idle_pct;
   int               rsp_idle_pct;
   logic             long_hold_req;
   int unsigned      last_x;
   int unsigned      last_y;

   planar_bitmap_fill_engine_top #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_PLANES(MAX_PLANES)
   ) uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   // response side: check, then pick the next ready level
   initial begin
      int hold_left;
      logic hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) screen_sb.check_result(rsp_read_data, rsp_was_read);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_req && !hold_taken) begin
            hold_left  = LONG_HOLD_CYCLES;
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic draw_req_type make_req(logic [MODE_W-1:0] mode, int unsigned x,
                                             int unsigned y, int unsigned w, int unsigned h,
                                             int unsigned color, int unsigned plane,
                                             int unsigned offset);
      draw_req_type r;
      r.mode        = mode;
      r.pos_x       = COORD_W'(x);
      r.pos_y       = COORD_W'(y);
      r.rect_width  = COORD_W'(w);
      r.rect_height = COORD_W'(h);
      r.color       = COLOR_W'(color);
      r.read_plane  = RPLANE_W'(plane);
      r.read_offset = ROFF_W'(offset);
      return r;
   endfunction

   function automatic draw_req_type random_req();
      draw_req_type r;
      int unsigned cols, rows, bpr, kind, y_edge;
      cols   = screen_sb.screen_cols();
      rows   = screen_sb.screen_rows();
      bpr    = cols >> PIXEL_SHIFT;
      y_edge = (rows > 4) ? 3 : rows - 1;
      r = make_req(MODE_W'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), $urandom_range(1023), $urandom_range(15),
                   $urandom_range(3), $urandom_range(65535));
      kind = $urandom_range(99);
      if (kind < 25) begin
         r.mode  = pbf_pkg::MODE_PIXEL;
         r.pos_x = COORD_W'($urandom_range(cols - 1));
         r.pos_y = COORD_W'($urandom_range(rows - 1));
      end else if (kind < 50) begin
         r.mode        = pbf_pkg::MODE_FILL;
         r.pos_x       = COORD_W'($urandom_range(cols - 1));
         r.pos_y       = COORD_W'($urandom_range(rows - 1));
         r.rect_width  = COORD_W'($urandom_range(48, 1));
         r.rect_height = COORD_W'($urandom_range(6, 1));
      end else if (kind < 58) begin
         // clip against the right and bottom edges
         r.mode  = pbf_pkg::MODE_FILL;
         r.pos_x = COORD_W'(cols - 1 - $urandom_range(7));
         r.pos_y = COORD_W'(rows - 1 - $urandom_range(y_edge));
      end else if (kind < 63) begin
         r.mode = $urandom_range(1) ? pbf_pkg::MODE_PIXEL : pbf_pkg::MODE_FILL;
         if ($urandom_range(1)) r.pos_x = COORD_W'($urandom_range(1023, cols));
         else r.pos_y = COORD_W'($urandom_range(1023, rows));
      end else if (kind < 66) begin
         r.mode  = pbf_pkg::MODE_FILL;
         r.pos_x = COORD_W'($urandom_range(cols - 1));
         r.pos_y = COORD_W'($urandom_range(rows - 1));
         if ($urandom_range(1)) r.rect_width = '0;
         else r.rect_height = '0;
      end else if (kind < 93) begin
         r.mode = pbf_pkg::MODE_READ;
         if ($urandom_range(3) != 0)
            r.read_offset = ROFF_W'(last_y * bpr + (last_x >> PIXEL_SHIFT) + $urandom_range(1));
      end else begin
         r.mode = MODE_NONE;
      end
      if (kind < 66 && r.pos_x < cols && r.pos_y < rows) begin
         last_x = r.pos_x;
         last_y = r.pos_y;
      end
      return r;
   endfunction

   task automatic send_req(input draw_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= r.mode;
      req_pos_x       <= r.pos_x;
      req_pos_y       <= r.pos_y;
      req_rect_width  <= r.rect_width;
      req_rect_height <= r.rect_height;
      req_color       <= r.color;
      req_read_plane  <= r.read_plane;
      req_read_offset <= r.read_offset;
      do @(posedge clock); while (!req_ready);
      screen_sb.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (screen_sb.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic program_screen(input int unsigned w, input int unsigned h, input int unsigned p);
      csr_wr_en <= 1'b1;
      csr_index <= pbf_pkg::CSR_SCREEN_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      screen_sb.write_reg(pbf_pkg::CSR_SCREEN_WIDTH, CSR_DATA_W'(w));
      csr_index <= pbf_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      screen_sb.write_reg(pbf_pkg::CSR_SCREEN_HEIGHT, CSR_DATA_W'(h));
      csr_index <= pbf_pkg::CSR_PLANE_COUNT;
      csr_wdata <= CSR_DATA_W'(p);
      @(posedge clock);
      screen_sb.write_reg(pbf_pkg::CSR_PLANE_COUNT, CSR_DATA_W'(p));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned phase, n, cfg_w, cfg_h, cfg_p;
      screen_sb       = new();
      req_idle_pct    = 10;
      last_x          = 0;
      last_y          = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= '0;
      req_pos_x       <= '0;
      req_pos_y       <= '0;
      req_rect_width  <= '0;
      req_rect_height <= '0;
      req_color       <= '0;
      req_read_plane  <= '0;
      req_read_offset <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      long_hold_req   <= 1'b0;
      rsp_idle_pct    <= 78;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(pbf_pkg::MODE_PIXEL, 0, 0, 0, 0, 15, 0, 0));
      send_req(make_req(pbf_pkg::MODE_PIXEL, 639, 479, 0, 0, 15, 0, 0));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 3, 0));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 3, 38399));
      send_req(make_req(pbf_pkg::MODE_PIXEL, 640, 0, 0, 0, 15, 0, 0));
      send_req(make_req(pbf_pkg::MODE_PIXEL, 0, 480, 0, 0, 15, 0, 0));
      send_req(make_req(pbf_pkg::MODE_FILL, 1023, 1023, 1023, 1023, 15, 0, 0));
      send_req(make_req(pbf_pkg::MODE_FILL, 3, 2, 13, 3, 4'b0101, 0, 0));
      send_req(make_req(pbf_pkg::MODE_FILL, 16, 5, 0, 5, 15, 0, 0));
      send_req(make_req(pbf_pkg::MODE_FILL, 16, 5, 5, 0, 15, 0, 0));
      send_req(make_req(pbf_pkg::MODE_FILL, 5, 10, 2, 1, 15, 0, 0));
      send_req(make_req(pbf_pkg::MODE_FILL, 630, 470, 1023, 1023, 4'b1010, 0, 0));
      drain();
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 1, 470 * 80 + 78));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 2, 2 * 80));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 10 * 80));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 2, 38400));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 3, 65535));
      send_req(make_req(MODE_NONE, 1023, 1023, 1023, 1023, 15, 3, 65535));
      send_req(make_req(pbf_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(pbf_pkg::MODE_FILL, 0, 0, 640, 480, 4'b1000, 0, 0));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 3, 12345));
      send_req(make_req(pbf_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 38399));
      drain();

      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin cfg_w = 640;  cfg_h = 480; cfg_p = 4; end
            1: begin cfg_w = 8;    cfg_h = 1;   cfg_p = 1; end
            2: begin cfg_w = 100;  cfg_h = 37;  cfg_p = 3; end
            3: begin cfg_w = 1023; cfg_h = 511; cfg_p = 7; end
            4: begin cfg_w = 0;    cfg_h = 0;   cfg_p = 0; end
            5: begin cfg_w = 64;   cfg_h = 20;  cfg_p = 2; end
            6: begin cfg_w = 200;  cfg_h = 60;  cfg_p = 4; end
            7: begin cfg_w = 17;   cfg_h = 3;   cfg_p = 2; end
            default: begin cfg_w = 640; cfg_h = 480; cfg_p = 1; end
         endcase
         if (phase < 3) begin
            req_idle_pct = 10;
            rsp_idle_pct <= 78;
         end else if (phase < 6) begin
            req_idle_pct = 78;
            rsp_idle_pct <= 10;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         program_screen(cfg_w, cfg_h, cfg_p);
         for (n = 0; n < 100; n++) begin
            if (phase == 6 && n == 30) long_hold_req <= 1'b1;
            send_req(random_req());
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (screen_sb.failures == 0 && screen_sb.outstanding() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+src
src/pbf_pkg.sv
src/pbf_store.sv
src/pbf_seq.sv
src/planar_bitmap_fill_engine_top.sv
sim/tb_top.sv
